/* rtl/dps_pkg.sv */
// Shared constants, codes and helper functions for the pendulum step core.
`timescale 1ns / 1ps
package dps_pkg;

    localparam int DATA_W       = 32;
    localparam int CORDIC_STEPS = 30;

    // Fixed-point constants
    localparam logic signed [32:0] TWO_PI_Q24  = 33'sd105414357;
    localparam logic signed [32:0] BIN_PER_RAD = 33'sd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
    localparam logic signed [31:0] SAT_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_MIN     = 32'sh80000000;

    // Operation codes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_HOLD    = 2'd1;
    localparam logic [1:0] OP_PLACE   = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_LEN_U  = 3'd0;
    localparam logic [2:0] REG_LEN_L  = 3'd1;
    localparam logic [2:0] REG_MASS_U = 3'd2;
    localparam logic [2:0] REG_MASS_L = 3'd3;
    localparam logic [2:0] REG_GRAV   = 3'd4;
    localparam logic [2:0] REG_STEP   = 3'd5;
    localparam logic [2:0] REG_DAMP_U = 3'd6;
    localparam logic [2:0] REG_DAMP_L = 3'd7;

    // Saturate a wide signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF) begin
            r = SAT_MAX;
        end else if (v < -36'sh080000000) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Sign-extend 32 to 36 bits
    function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    // Unsigned Q8.16 register to signed Q.24, saturated
    function automatic logic signed [31:0] reg_q24(input logic [23:0] v);
        logic signed [31:0] r;
        if (v[23]) begin
            r = SAT_MAX;
        end else begin
            r = {v, 8'd0};
        end
        return r;
    endfunction

    // Arctangent table, Q2.30 of a quarter turn scale
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/dps_cordic.sv */
// Iterative CORDIC sine/cosine unit, one rotation per cycle.
`timescale 1ns / 1ps
module dps_cordic
    import dps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] sin_out,
    output logic signed [31:0] cos_out
);

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         step_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;

    logic [31:0]        folded;
    logic               fold;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [33:0] xr;
    logic signed [33:0] yr;

    // Fold angle into +-90 degrees
    always_comb begin
        fold   = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        folded = fold ? (angle + 32'h80000000) : angle;
    end

    // One rotation
    always_comb begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = {4'd0, atan_entry(step_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 5'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotation datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= fold;
            x_reg   <= CORDIC_GAIN;
            y_reg   <= 34'sd0;
            z_reg   <= {{2{folded[31]}}, folded};
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    // Round to Q.24 and unfold
    always_comb begin
        xr = (x_reg + 34'sd32) >>> 6;
        yr = (y_reg + 34'sd32) >>> 6;
        if (neg_reg) begin
            xr = -xr;
            yr = -yr;
        end
        sin_out = yr[31:0];
        cos_out = xr[31:0];
    end

    assign done = done_reg;

endmodule

/* rtl/dps_div.sv */
// Iterative restoring divider for signed Q.24 quotients, one bit per cycle.
`timescale 1ns / 1ps
module dps_div
    import dps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    localparam int         DVD_W    = DATA_W + 24;
    localparam logic [5:0] LAST_BIT = 6'(DVD_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        rem_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVD_W-1:0]   q_reg;
    logic [31:0]        ud_reg;
    logic               neg_reg;
    logic signed [31:0] quot_reg;

    logic [31:0]        un;
    logic [31:0]        ud;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [32:0]        rem_new;
    logic [DVD_W-1:0]   q_new;
    logic signed [31:0] fit_q;

    always_comb begin
        un = num[31] ? 32'(-num) : num;
        ud = den[31] ? 32'(-den) : den;
    end

    // Restoring step and final saturation
    always_comb begin
        rem_sh  = {rem_reg[31:0], dvd_reg[DVD_W-1]};
        qbit    = (rem_sh >= {1'b0, ud_reg});
        rem_new = qbit ? (rem_sh - {1'b0, ud_reg}) : rem_sh;
        q_new   = {q_reg[DVD_W-2:0], qbit};
        if (neg_reg) begin
            if (q_new > DVD_W'(33'h080000000)) begin
                fit_q = SAT_MIN;
            end else begin
                fit_q = 32'(-q_new);
            end
        end else begin
            if (q_new > DVD_W'(33'h07FFFFFFF)) begin
                fit_q = SAT_MAX;
            end else begin
                fit_q = q_new[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'd0;
                if (den == 32'sd0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= 33'd0;
            q_reg   <= '0;
            dvd_reg <= {un, 24'd0};
            ud_reg  <= ud;
            neg_reg <= num[31] ^ den[31];
            if (den == 32'sd0) begin
                quot_reg <= num[31] ? SAT_MIN : SAT_MAX;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_new;
            q_reg   <= q_new;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            if (cnt_reg == LAST_BIT) begin
                quot_reg <= fit_q;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/double_pendulum_step_core.sv */
// Double pendulum stepper: sequencer around a shared multiplier, CORDIC and divider.
// Advance runs four sine/cosine runs, then 33 multiply/add steps with four divides
// between them, then the report; hold and place run only the report (two sine/cosine
// runs, position math, output). A zero divisor skips the divider's bit loop and returns a
// saturated quotient. One word in flight; s_tready is high only while idle.
// Reset (aresetn, synchronous): state clears, registers take defaults, no word pending.
`timescale 1ns / 1ps
module double_pendulum_step_core
    import dps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // place_angle_upper, place_angle_lower
    input  logic [1:0]   s_tuser,   // operation
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata    // angle_upper, angle_lower, velocity_upper,
                                    // velocity_lower, accel_upper, accel_lower,
                                    // pos_x_upper, pos_y_upper, pos_x_lower, pos_y_lower
);

    // Sequencer states, numbered in execution order
    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_CS_TU  = 6'd1;
    localparam logic [5:0] ST_CW_TU  = 6'd2;
    localparam logic [5:0] ST_CS_D   = 6'd3;
    localparam logic [5:0] ST_CW_D   = 6'd4;
    localparam logic [5:0] ST_CS_2D  = 6'd5;
    localparam logic [5:0] ST_CW_2D  = 6'd6;
    localparam logic [5:0] ST_CS_12  = 6'd7;
    localparam logic [5:0] ST_CW_12  = 6'd8;
    localparam logic [5:0] ST_M_WU   = 6'd9;
    localparam logic [5:0] ST_M_WL   = 6'd10;
    localparam logic [5:0] ST_M_VU1  = 6'd11;
    localparam logic [5:0] ST_M_VU2  = 6'd12;
    localparam logic [5:0] ST_M_VL1  = 6'd13;
    localparam logic [5:0] ST_M_VL2  = 6'd14;
    localparam logic [5:0] ST_A_MP   = 6'd15;
    localparam logic [5:0] ST_DS_R   = 6'd16;
    localparam logic [5:0] ST_DW_R   = 6'd17;
    localparam logic [5:0] ST_DS_P   = 6'd18;
    localparam logic [5:0] ST_DW_P   = 6'd19;
    localparam logic [5:0] ST_M_RC   = 6'd20;
    localparam logic [5:0] ST_A_DEN  = 6'd21;
    localparam logic [5:0] ST_M_GS   = 6'd22;
    localparam logic [5:0] ST_M_VC   = 6'd23;
    localparam logic [5:0] ST_A_VSUM = 6'd24;
    localparam logic [5:0] ST_M_A    = 6'd25;
    localparam logic [5:0] ST_M_B1   = 6'd26;
    localparam logic [5:0] ST_M_B2   = 6'd27;
    localparam logic [5:0] ST_M_C1   = 6'd28;
    localparam logic [5:0] ST_M_C2   = 6'd29;
    localparam logic [5:0] ST_A_N1   = 6'd30;
    localparam logic [5:0] ST_M_LD1  = 6'd31;
    localparam logic [5:0] ST_DS_A1  = 6'd32;
    localparam logic [5:0] ST_DW_A1  = 6'd33;
    localparam logic [5:0] ST_M_E    = 6'd34;
    localparam logic [5:0] ST_M_F1   = 6'd35;
    localparam logic [5:0] ST_M_F2   = 6'd36;
    localparam logic [5:0] ST_M_G1   = 6'd37;
    localparam logic [5:0] ST_M_G2   = 6'd38;
    localparam logic [5:0] ST_A_T    = 6'd39;
    localparam logic [5:0] ST_M_H    = 6'd40;
    localparam logic [5:0] ST_A_N2   = 6'd41;
    localparam logic [5:0] ST_M_LD2  = 6'd42;
    localparam logic [5:0] ST_DS_A2  = 6'd43;
    localparam logic [5:0] ST_DW_A2  = 6'd44;
    localparam logic [5:0] ST_M_HU   = 6'd45;
    localparam logic [5:0] ST_M_HL   = 6'd46;
    localparam logic [5:0] ST_A_OM   = 6'd47;
    localparam logic [5:0] ST_M_DU   = 6'd48;
    localparam logic [5:0] ST_M_DL   = 6'd49;
    localparam logic [5:0] ST_CS_RU  = 6'd50;
    localparam logic [5:0] ST_CW_RU  = 6'd51;
    localparam logic [5:0] ST_M_XU   = 6'd52;
    localparam logic [5:0] ST_M_YU   = 6'd53;
    localparam logic [5:0] ST_CS_RL  = 6'd54;
    localparam logic [5:0] ST_CW_RL  = 6'd55;
    localparam logic [5:0] ST_M_XL   = 6'd56;
    localparam logic [5:0] ST_A_XL   = 6'd57;
    localparam logic [5:0] ST_M_YL   = 6'd58;
    localparam logic [5:0] ST_A_YL   = 6'd59;
    localparam logic [5:0] ST_OUT    = 6'd60;

    // Multiplier shift codes
    localparam logic [1:0] SH_16 = 2'd0;
    localparam logic [1:0] SH_24 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    logic [5:0] state_reg;
    logic [5:0] state_next;

    // Configuration registers
    logic [23:0] len_u_reg, len_l_reg, mass_u_reg, mass_l_reg, grav_reg;
    logic [31:0] step_reg;
    logic [15:0] damp_u_reg, damp_l_reg;

    // Architectural state
    logic [31:0]        theta_u_reg, theta_l_reg;
    logic signed [31:0] omega_u_reg, omega_l_reg;
    logic signed [31:0] acc_u_reg, acc_l_reg;

    // Working registers
    logic signed [31:0] su_reg, cu_reg, sd_reg, cd_reg, c2d_reg, s12_reg;
    logic signed [31:0] wu_reg, wl_reg, vu_reg, vl_reg, tmp_reg;
    logic signed [31:0] mm_reg, pp_reg, r_reg, p_reg, den_reg, gs_reg, vsum_reg;
    logic signed [31:0] ta_reg, tb_reg, tc_reg, n_reg, a1_reg;
    logic signed [31:0] xu_reg, yu_reg, xl_reg, yl_reg;

    logic               m_tvalid_reg;
    logic [319:0]       m_tdata_reg;

    // Register values in Q.24
    logic signed [31:0] len_u_q, len_l_q, mass_u_q, mass_l_q, grav_q;

    // Shared units
    logic               cor_start, cor_done;
    logic [31:0]        cor_angle;
    logic signed [31:0] cor_sin, cor_cos;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_den, div_quot;

    logic signed [32:0] mul_a, mul_b;
    logic [1:0]         mul_sh;
    logic [32:0]        mag_a, mag_b;
    logic [65:0]        prod, prod_sh;
    logic               mul_neg;
    logic signed [31:0] mul_res;

    logic [31:0]        ang_d;
    logic               out_free;
    logic signed [31:0] om_u_sum, om_l_sum;

    always_comb begin
        len_u_q  = reg_q24(len_u_reg);
        len_l_q  = reg_q24(len_l_reg);
        mass_u_q = reg_q24(mass_u_reg);
        mass_l_q = reg_q24(mass_l_reg);
        grav_q   = reg_q24(grav_reg);
        ang_d    = theta_u_reg - theta_l_reg;
        out_free = !m_tvalid_reg || m_tready;
        om_u_sum = sat32(ext36(omega_u_reg) + ext36(acc_u_reg));
        om_l_sum = sat32(ext36(omega_l_reg) + ext36(acc_l_reg));
    end

    dps_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_out (cor_sin),
        .cos_out (cor_cos)
    );

    dps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // CORDIC launch
    always_comb begin
        cor_start = 1'b0;
        cor_angle = theta_u_reg;
        case (state_reg)
            ST_CS_TU: begin
                cor_start = 1'b1;
            end
            ST_CS_D: begin
                cor_start = 1'b1;
                cor_angle = ang_d;
            end
            ST_CS_2D: begin
                cor_start = 1'b1;
                cor_angle = ang_d + ang_d;
            end
            ST_CS_12: begin
                cor_start = 1'b1;
                cor_angle = ang_d - theta_l_reg;
            end
            ST_CS_RU: begin
                cor_start = 1'b1;
            end
            ST_CS_RL: begin
                cor_start = 1'b1;
                cor_angle = theta_l_reg;
            end
            default: begin
                cor_start = 1'b0;
            end
        endcase
    end

    // Divider launch
    always_comb begin
        div_start = 1'b0;
        div_num   = mass_l_q;
        div_den   = mm_reg;
        case (state_reg)
            ST_DS_R: begin
                div_start = 1'b1;
            end
            ST_DS_P: begin
                div_start = 1'b1;
                div_num   = pp_reg;
            end
            ST_DS_A1, ST_DS_A2: begin
                div_start = 1'b1;
                div_num   = n_reg;
                div_den   = tmp_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Multiplier operand select
    always_comb begin
        mul_a  = {omega_u_reg[31], omega_u_reg};
        mul_b  = TWO_PI_Q24;
        mul_sh = SH_24;
        case (state_reg)
            ST_M_WU: begin
                mul_sh = SH_32;
            end
            ST_M_WL: begin
                mul_a  = {omega_l_reg[31], omega_l_reg};
                mul_sh = SH_32;
            end
            ST_M_VU1: begin
                mul_a = {wu_reg[31], wu_reg};
                mul_b = {wu_reg[31], wu_reg};
            end
            ST_M_VU2: begin
                mul_a = {tmp_reg[31], tmp_reg};
                mul_b = {len_u_q[31], len_u_q};
            end
            ST_M_VL1: begin
                mul_a = {wl_reg[31], wl_reg};
                mul_b = {wl_reg[31], wl_reg};
            end
            ST_M_VL2: begin
                mul_a = {tmp_reg[31], tmp_reg};
                mul_b = {len_l_q[31], len_l_q};
            end
            ST_M_RC: begin
                mul_a = {r_reg[31], r_reg};
                mul_b = {c2d_reg[31], c2d_reg};
            end
            ST_M_GS: begin
                mul_a  = {grav_q[31], grav_q};
                mul_b  = {1'b0, step_reg};
                mul_sh = SH_32;
            end
            ST_M_VC: begin
                mul_a = {vu_reg[31], vu_reg};
                mul_b = {cd_reg[31], cd_reg};
            end
            ST_M_A: begin
                mul_a = {gs_reg[31], gs_reg};
                mul_b = {su_reg[31], su_reg};
            end
            ST_M_B1: begin
                mul_a = {gs_reg[31], gs_reg};
                mul_b = {s12_reg[31], s12_reg};
            end
            ST_M_B2: begin
                mul_a = {r_reg[31], r_reg};
                mul_b = {tb_reg[31], tb_reg};
            end
            ST_M_C1: begin
                mul_a = {sd_reg[31], sd_reg};
                mul_b = {vsum_reg[31], vsum_reg};
            end
            ST_M_C2: begin
                mul_a = {r_reg[31], r_reg};
                mul_b = {tc_reg[31], tc_reg};
            end
            ST_M_LD1: begin
                mul_a = {len_u_q[31], len_u_q};
                mul_b = {den_reg[31], den_reg};
            end
            ST_M_E: begin
                mul_a = {vu_reg[31], vu_reg};
                mul_b = {p_reg[31], p_reg};
            end
            ST_M_F1: begin
                mul_a = {gs_reg[31], gs_reg};
                mul_b = {p_reg[31], p_reg};
            end
            ST_M_F2: begin
                mul_a = {tb_reg[31], tb_reg};
                mul_b = {cu_reg[31], cu_reg};
            end
            ST_M_G1: begin
                mul_a = {vl_reg[31], vl_reg};
                mul_b = {r_reg[31], r_reg};
            end
            ST_M_G2: begin
                mul_a = {tc_reg[31], tc_reg};
                mul_b = {cd_reg[31], cd_reg};
            end
            ST_M_H: begin
                mul_a = {sd_reg[31], sd_reg};
                mul_b = {tmp_reg[31], tmp_reg};
            end
            ST_M_LD2: begin
                mul_a = {len_l_q[31], len_l_q};
                mul_b = {den_reg[31], den_reg};
            end
            ST_M_HU: begin
                mul_a = {a1_reg[31], a1_reg};
                mul_b = BIN_PER_RAD;
            end
            ST_M_HL: begin
                mul_a = {div_quot[31], div_quot};
                mul_b = BIN_PER_RAD;
            end
            ST_M_DU: begin
                mul_b  = {17'd0, damp_u_reg};
                mul_sh = SH_16;
            end
            ST_M_DL: begin
                mul_a  = {omega_l_reg[31], omega_l_reg};
                mul_b  = {17'd0, damp_l_reg};
                mul_sh = SH_16;
            end
            ST_M_XU: begin
                mul_a = {len_u_q[31], len_u_q};
                mul_b = {su_reg[31], su_reg};
            end
            ST_M_YU: begin
                mul_a = {len_u_q[31], len_u_q};
                mul_b = {cu_reg[31], cu_reg};
            end
            ST_M_XL: begin
                mul_a = {len_l_q[31], len_l_q};
                mul_b = {sd_reg[31], sd_reg};
            end
            ST_M_YL: begin
                mul_a = {len_l_q[31], len_l_q};
                mul_b = {cd_reg[31], cd_reg};
            end
            default: begin
                mul_sh = SH_24;
            end
        endcase
    end

    // Shared multiplier: magnitude product, shift toward zero, saturate
    always_comb begin
        mag_a   = mul_a[32] ? 33'(-mul_a) : mul_a;
        mag_b   = mul_b[32] ? 33'(-mul_b) : mul_b;
        mul_neg = mul_a[32] ^ mul_b[32];
        prod    = mag_a * mag_b;
        case (mul_sh)
            SH_16:   prod_sh = prod >> 16;
            SH_32:   prod_sh = prod >> 32;
            default: prod_sh = prod >> 24;
        endcase
        if (mul_neg) begin
            mul_res = (prod_sh > 66'h080000000) ? SAT_MIN : 32'(-prod_sh);
        end else begin
            mul_res = (prod_sh > 66'h07FFFFFFF) ? SAT_MAX : prod_sh[31:0];
        end
    end

    // Sequencer: steps run in numeric order, waits hold on unit done or a free output
    always_comb begin
        state_next = state_reg + 6'd1;
        case (state_reg)
            ST_IDLE: begin
                if (!s_tvalid) begin
                    state_next = ST_IDLE;
                end else if (s_tuser == OP_ADVANCE) begin
                    state_next = ST_CS_TU;
                end else begin
                    state_next = ST_CS_RU;
                end
            end
            ST_CW_TU, ST_CW_D, ST_CW_2D, ST_CW_12, ST_CW_RU, ST_CW_RL: begin
                if (!cor_done) state_next = state_reg;
            end
            ST_DW_R, ST_DW_P, ST_DW_A1, ST_DW_A2: begin
                if (!div_done) state_next = state_reg;
            end
            ST_OUT: begin
                state_next = out_free ? ST_IDLE : ST_OUT;
            end
            default: begin
                state_next = state_reg + 6'd1;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            len_u_reg    <= 24'd65536;
            len_l_reg    <= 24'd65536;
            mass_u_reg   <= 24'd655360;
            mass_l_reg   <= 24'd655360;
            grav_reg     <= 24'd642908;
            step_reg     <= 32'd1193046;
            damp_u_reg   <= 16'd65535;
            damp_l_reg   <= 16'd65535;
            theta_u_reg  <= 32'd0;
            theta_l_reg  <= 32'd0;
            omega_u_reg  <= 32'sd0;
            omega_l_reg  <= 32'sd0;
            acc_u_reg    <= 32'sd0;
            acc_l_reg    <= 32'sd0;
        end else begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_LEN_U:  len_u_reg  <= cfg_wr_data[23:0];
                    REG_LEN_L:  len_l_reg  <= cfg_wr_data[23:0];
                    REG_MASS_U: mass_u_reg <= cfg_wr_data[23:0];
                    REG_MASS_L: mass_l_reg <= cfg_wr_data[23:0];
                    REG_GRAV:   grav_reg   <= cfg_wr_data[23:0];
                    REG_STEP:   step_reg   <= cfg_wr_data;
                    REG_DAMP_U: damp_u_reg <= cfg_wr_data[15:0];
                    REG_DAMP_L: damp_l_reg <= cfg_wr_data[15:0];
                    default:    len_u_reg  <= len_u_reg;
                endcase
            end

            // Place loads angles, clears velocities
            if (state_reg == ST_IDLE && s_tvalid && s_tuser == OP_PLACE) begin
                theta_u_reg <= s_tdata[31:0];
                theta_l_reg <= s_tdata[63:32];
                omega_u_reg <= 32'sd0;
                omega_l_reg <= 32'sd0;
            end

            case (state_reg)
                ST_M_HU: acc_u_reg <= mul_res;
                ST_M_HL: acc_l_reg <= mul_res;
                ST_A_OM: begin
                    omega_u_reg <= om_u_sum;
                    omega_l_reg <= om_l_sum;
                    theta_u_reg <= theta_u_reg + om_u_sum;
                    theta_l_reg <= theta_l_reg + om_l_sum;
                end
                ST_M_DU: omega_u_reg <= mul_res;
                ST_M_DL: omega_l_reg <= mul_res;
                default: acc_u_reg <= acc_u_reg;
            endcase

            // Output word handshake: a new word wins over the handoff of the old one
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CW_TU, ST_CW_RU: begin
                su_reg <= cor_sin;
                cu_reg <= cor_cos;
            end
            ST_CW_D, ST_CW_RL: begin
                sd_reg <= cor_sin;
                cd_reg <= cor_cos;
            end
            ST_CW_2D:  c2d_reg <= cor_cos;
            ST_CW_12:  s12_reg <= cor_sin;
            ST_M_WU:   wu_reg  <= mul_res;
            ST_M_WL:   wl_reg  <= mul_res;
            ST_M_VU1, ST_M_VL1, ST_M_RC, ST_M_VC, ST_M_LD1, ST_M_H, ST_M_LD2,
            ST_M_XL, ST_M_YL: begin
                tmp_reg <= mul_res;
            end
            ST_M_VU2:  vu_reg  <= mul_res;
            ST_M_VL2:  vl_reg  <= mul_res;
            ST_A_MP: begin
                mm_reg <= sat32(ext36(mass_u_q) + ext36(mass_u_q) + ext36(mass_l_q));
                pp_reg <= sat32(ext36(mass_u_q) + ext36(mass_l_q));
            end
            ST_DW_R:   r_reg   <= div_quot;
            ST_DW_P:   p_reg   <= div_quot;
            ST_A_DEN:  den_reg <= sat32(ext36(ONE_Q24) - ext36(tmp_reg));
            ST_M_GS:   gs_reg  <= mul_res;
            ST_A_VSUM: vsum_reg <= sat32(ext36(vl_reg) + ext36(tmp_reg));
            ST_M_A, ST_M_E: ta_reg <= mul_res;
            ST_M_B1, ST_M_B2, ST_M_F1, ST_M_F2: tb_reg <= mul_res;
            ST_M_C1, ST_M_C2, ST_M_G1, ST_M_G2: tc_reg <= mul_res;
            ST_A_N1: begin
                n_reg <= sat32(-ext36(ta_reg) - ext36(tb_reg)
                               - ext36(tc_reg) - ext36(tc_reg));
            end
            ST_DW_A1:  a1_reg  <= div_quot;
            ST_A_T:    tmp_reg <= sat32(ext36(ta_reg) + ext36(tb_reg) + ext36(tc_reg));
            ST_A_N2:   n_reg   <= sat32(ext36(tmp_reg) + ext36(tmp_reg));
            ST_M_XU:   xu_reg  <= mul_res;
            ST_M_YU:   yu_reg  <= mul_res;
            ST_A_XL:   xl_reg  <= sat32(ext36(xu_reg) + ext36(tmp_reg));
            ST_A_YL:   yl_reg  <= sat32(ext36(yu_reg) + ext36(tmp_reg));
            default:   tmp_reg <= tmp_reg;
        endcase
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {yl_reg, xl_reg, yu_reg, xu_reg, acc_l_reg, acc_u_reg,
                            omega_l_reg, omega_u_reg, theta_l_reg, theta_u_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* bench/tb.sv */
// Self-checking bench for the double pendulum step core: predictor, scoreboard, drivers.
`timescale 1ns / 1ps
module tb;
    import dps_pkg::*;

    localparam int STALL_LIMIT = 8000;
    localparam int BACKLOG_HOLD = 1500;
    localparam int RANDOM_PER_PHASE = 205;

    // unused operation code, behaves as hold
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Pendulum state tracker and result store
    class pendulum_sb;
        bit [31:0]  cfg [8];
        bit [31:0]  th_u, th_l;
        longint     om_u, om_l, acc_u, acc_l;
        longint     atan_q30 [30];
        bit [319:0] pending [$];
        int         errors, words_seen, items_seen;
        string      names [10];

        function new();
            atan_q30 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                         81, 41, 20, 10, 5, 3, 1};
            names = '{"angle_upper", "angle_lower", "velocity_upper", "velocity_lower",
                      "accel_upper", "accel_lower", "pos_x_upper", "pos_y_upper",
                      "pos_x_lower", "pos_y_lower"};
            cfg = '{32'd65536, 32'd65536, 32'd655360, 32'd655360, 32'd642908,
                    32'd1193046, 32'd65535, 32'd65535};
            th_u = 0; th_l = 0; om_u = 0; om_l = 0; acc_u = 0; acc_l = 0;
            errors = 0; words_seen = 0; items_seen = 0;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) << (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // exact product, shifted toward zero, then saturated
        function longint scale_mul(longint a, longint b, int sh, int bits);
            logic signed [127:0] pa, pb, p;
            logic [127:0] m, cap;
            bit neg;
            pa = a; pb = b;
            p = pa * pb;
            neg = (a < 0) != (b < 0);
            m = (p < 0) ? -p : p;
            m = m >> sh;
            cap = 128'd1 << (bits - 1);
            if (m > cap - 1 + neg) return neg ? -longint'(cap) : longint'(cap) - 1;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint fix_mul(longint a, longint b);
            return scale_mul(a, b, 24, 32);
        endfunction

        function longint div_q(longint n, longint d);
            logic [127:0] un, ud, q, cap;
            bit neg;
            cap = 128'd1 << 31;
            if (d == 0) return (n < 0) ? -longint'(cap) : longint'(cap) - 1;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q = (un << 24) / ud;
            neg = (n < 0) != (d < 0);
            if (q > cap - 1 + neg) return neg ? -longint'(cap) : longint'(cap) - 1;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint len_q24(int k);
            return clamp(longint'({32'd0, cfg[k]}) << 8, 32);
        endfunction

        // CORDIC rotation after folding into the right half plane
        function void sin_cos(bit [31:0] a, output longint s, output longint c);
            bit neg;
            longint x, y, z, dx, dy;
            neg = 0;
            if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
                a = a + 32'h80000000;
                neg = 1;
            end
            x = 652032874; y = 0;
            z = $signed(a);
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q30[i];
                end else begin
                    x += dx; y -= dy; z += atan_q30[i];
                end
            end
            x = (x + 32) >>> 6;
            y = (y + 32) >>> 6;
            s = neg ? -y : y;
            c = neg ? -x : x;
        endfunction

        function void advance();
            longint lu, ll, mu, ml, g, su, cu, sd, cd, s2d, c2d, s12, c12;
            longint wu, wl, vu, vl, mt, ps, r, p, den, gs, vsum, n1, n2, t, a1, a2;
            bit [31:0] d;
            lu = len_q24(0); ll = len_q24(1); mu = len_q24(2); ml = len_q24(3);
            g = len_q24(4);
            d = th_u - th_l;
            sin_cos(th_u, su, cu);
            sin_cos(d, sd, cd);
            sin_cos(d + d, s2d, c2d);
            sin_cos(th_u - th_l - th_l, s12, c12);
            wu = scale_mul(om_u, 105414357, 32, 32);
            wl = scale_mul(om_l, 105414357, 32, 32);
            vu = fix_mul(fix_mul(wu, wu), lu);
            vl = fix_mul(fix_mul(wl, wl), ll);
            mt = clamp(mu + mu + ml, 32);
            ps = clamp(mu + ml, 32);
            r = div_q(ml, mt);
            p = div_q(ps, mt);
            den = clamp((longint'(1) << 24) - fix_mul(r, c2d), 32);
            gs = scale_mul(g, longint'({32'd0, cfg[5]}), 32, 32);
            vsum = clamp(vl + fix_mul(vu, cd), 32);
            n1 = clamp(-fix_mul(gs, su) - fix_mul(r, fix_mul(gs, s12))
                       - 2 * fix_mul(r, fix_mul(sd, vsum)), 32);
            a1 = div_q(n1, fix_mul(lu, den));
            t = clamp(fix_mul(vu, p) + fix_mul(fix_mul(gs, p), cu)
                      + fix_mul(fix_mul(vl, r), cd), 32);
            n2 = clamp(2 * fix_mul(sd, t), 32);
            a2 = div_q(n2, fix_mul(ll, den));
            acc_u = scale_mul(a1, 683565276, 24, 32);
            acc_l = scale_mul(a2, 683565276, 24, 32);
            om_u = clamp(om_u + acc_u, 32);
            om_l = clamp(om_l + acc_l, 32);
            th_u = th_u + om_u[31:0];
            th_l = th_l + om_l[31:0];
            om_u = scale_mul(om_u, longint'({32'd0, cfg[6]}), 16, 32);
            om_l = scale_mul(om_l, longint'({32'd0, cfg[7]}), 16, 32);
        endfunction

        function void write_reg(bit [2:0] idx, bit [31:0] val);
            cfg[idx] = (idx == REG_STEP) ? val :
                       (idx == REG_DAMP_U || idx == REG_DAMP_L) ? {16'd0, val[15:0]} :
                       {8'd0, val[23:0]};
        endfunction

        // accepted input word: update state, queue the report it causes
        function void note(bit [1:0] op, bit [63:0] data);
            longint su, cu, sl, cl, xu, yu, xl, yl, lu, ll;
            bit [319:0] word;
            items_seen++;
            if (op == OP_ADVANCE) begin
                advance();
            end else if (op == OP_PLACE) begin
                th_u = data[31:0];
                th_l = data[63:32];
                om_u = 0;
                om_l = 0;
            end
            lu = len_q24(0);
            ll = len_q24(1);
            sin_cos(th_u, su, cu);
            sin_cos(th_l, sl, cl);
            xu = fix_mul(lu, su);
            yu = fix_mul(lu, cu);
            xl = clamp(xu + fix_mul(ll, sl), 32);
            yl = clamp(yu + fix_mul(ll, cl), 32);
            word = {32'(yl), 32'(xl), 32'(yu), 32'(xu), 32'(acc_l), 32'(acc_u),
                    32'(om_l), 32'(om_u), th_l, th_u};
            pending = {pending, word};
        endfunction

        function void check(bit [319:0] got);
            bit [319:0] want;
            words_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int f = 0; f < 10; f++) begin
                if (want[f*32 +: 32] != got[f*32 +: 32]) begin
                    $display("%0t: %s expected %h actual %h", $time, names[f],
                             want[f*32 +: 32], got[f*32 +: 32]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_wr_index = '0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;

    pendulum_sb sb = new();
    bit  no_idle = 0;
    bit  backlog_req = 0;
    int  quiet_cycles = 0;

    double_pendulum_step_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // handshake monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // result side: random back-pressure, one long hold when asked
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            w = no_idle ? 0 : $urandom_range(0, 3);
            if (backlog_req) begin
                m_tready <= 1'b0;
                repeat (BACKLOG_HOLD) @(negedge aclk);
                backlog_req = 0;
            end else if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // offer one word; called at a falling edge, returns at a falling edge
    task automatic send_word(bit [1:0] op, bit [63:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic load_regs(bit [31:0] v [8]);
        for (int k = 0; k < 8; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= 3'(k);
            cfg_wr_data <= v[k];
            sb.write_reg(3'(k), v[k]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_words(int n);
        int pick;
        bit [63:0] d;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            d = {$urandom, $urandom};
            if (pick < 74) send_word(OP_ADVANCE, d);
            else if (pick < 86) send_word(OP_PLACE, d);
            else if (pick < 89) send_word(OP_PLACE, {d[63:62], 30'd0, d[31:30], 30'd0});
            else if (pick < 96) send_word(OP_HOLD, d);
            else send_word(OP_SPARE, d);
        end
    endtask

    initial begin
        bit [31:0] v [8];
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset state, angle extremes, every operation
        send_word(OP_HOLD, 64'd0);
        send_word(OP_ADVANCE, 64'd0);
        send_word(OP_PLACE, {32'hFFFFFFFF, 32'h00000000});
        send_word(OP_PLACE, {32'h00000000, 32'hFFFFFFFF});
        send_word(OP_PLACE, {32'h80000000, 32'h40000000});
        send_word(OP_PLACE, {32'hC0000000, 32'h3FFFFFFF});
        send_word(OP_PLACE, {32'h7FFFFFFF, 32'h80000000});
        for (int i = 0; i < 6; i++) send_word(OP_ADVANCE, 64'hFFFFFFFF_FFFFFFFF);
        send_word(OP_SPARE, 64'hFFFFFFFF_FFFFFFFF);
        send_word(OP_HOLD, 64'hA5A5A5A5_5A5A5A5A);
        send_word(OP_PLACE, {32'h20000000, 32'hE0000000});
        for (int i = 0; i < 5; i++) send_word(OP_ADVANCE, 64'd0);
        send_word(OP_PLACE, {32'h40000000, 32'h40000000});
        send_word(OP_ADVANCE, 64'd0);
        drain();

        // defaults written explicitly, receiver held off once to back up the input
        v = '{32'd65536, 32'd65536, 32'd655360, 32'd655360, 32'd642908, 32'd1193046,
              32'd65535, 32'd65535};
        load_regs(v);
        backlog_req = 1;
        random_words(RANDOM_PER_PHASE);
        drain();

        // physically plausible random settings
        v = '{$urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000),
              $urandom_range(32'h1000, 32'h200000), $urandom_range(32'h1000, 32'h200000),
              $urandom_range(32'h10000, 32'hF0000), $urandom,
              $urandom_range(32'hF000, 32'hFFFF), $urandom_range(0, 32'hFFFF)};
        load_regs(v);
        random_words(RANDOM_PER_PHASE);
        drain();

        // all registers at their maximum: saturating conversions
        v = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        load_regs(v);
        no_idle = 1;
        random_words(RANDOM_PER_PHASE);
        drain();
        no_idle = 0;

        // all zero: zero divisors everywhere, no damping retention
        v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        load_regs(v);
        random_words(RANDOM_PER_PHASE / 2);
        drain();

        // raw random register values over the full width
        v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
        load_regs(v);
        random_words(RANDOM_PER_PHASE);
        drain();

        $display("Ran %0d input words over six register settings, %0d result words checked.",
                 sb.items_seen, sb.words_seen);
        $display("Settings covered defaults, random, all-max and all-zero registers.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
